FILE: hw/rtl/rcsa_pkg.sv
// Shared types, constants and helpers for the rotated cell statistics accumulator.
`default_nettype none

package rcsa_pkg;

  localparam int OP_W          = 2;
  localparam int POS_W         = 10;
  localparam int SAMPLE_W      = 16;
  localparam int CH_W          = 2;
  localparam int SUM_W         = 40;
  localparam int COUNT_W       = 24;
  localparam int SAMPLE_INPUTS = 4;
  localparam int EVENT_SAMPLES = 1000;
  localparam int DEF_CELLS     = 1024;
  localparam int DEF_CHANNELS  = 4;
  // Cell index width at the largest supported array size.
  localparam int CELL_MAX_W    = 12;
  // Conditional subtract steps that reduce an (offset + position) sum below CELLS.
  localparam int MOD_STEPS     = 7;

  localparam logic [OP_W-1:0] OP_ACCUM      = 2'd0;
  localparam logic [OP_W-1:0] OP_READ       = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [POS_W-1:0]    sample_pos;
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
    logic [POS_W-1:0]    offset_pair_a;
    logic [POS_W-1:0]    offset_pair_b;
    logic [POS_W-1:0]    read_cell;
    logic [CH_W-1:0]     read_channel;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   cell_sum;
    logic [COUNT_W-1:0] cell_count;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               sat;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic upd;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_out;
    logic out_free;
  } dp_status_t;

  // Reduce a value below 2^(POS_W+1) modulo cells by shifted conditional subtracts.
  function automatic logic [CELL_MAX_W-1:0] mod_cells(input logic [POS_W:0] v,
                                                       input int unsigned cells);
    int unsigned r;
    r = 32'(v);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (cells << k)) begin
        r = r - (cells << k);
      end
    end
    return r[CELL_MAX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rcsa_ctrl.sv
// Control state machine: clearing pass, item sequencing and result hand-off.
`default_nettype none

module rcsa_ctrl
  import rcsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = rst || (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold here while a read result has nowhere to go
        if (!status.need_out || status.out_free) begin
          cmd.upd    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rcsa_datapath.sv
// Datapath: item registers, per-channel cell memories, saturating update, result register.
`default_nettype none

module rcsa_datapath
  import rcsa_pkg::*;
#(
  parameter int CELLS = DEF_CELLS,
  parameter int LANES = SAMPLE_INPUTS
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  in_item_t   item_data,
  output out_item_t  result_data,
  output logic       result_valid,
  input  logic       result_stall
);

  localparam int CELL_W = $clog2(CELLS);
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic                is_accum;
  logic                is_read;
  logic                rd_clear;
  logic                rd_zero;
  logic [CELL_W-1:0]   pair_addr [2];
  logic [CELL_W-1:0]   rd_addr;
  logic [LANE_W-1:0]   rd_lane;
  logic [SAMPLE_W-1:0] smp [LANES];
  logic [CELL_W-1:0]   clr_addr;

  logic [SAMPLE_W-1:0] in_smp [SAMPLE_INPUTS];
  logic                pos_ok;
  logic                ch_ok;
  logic [POS_W:0]      sum_a;
  logic [POS_W:0]      sum_b;
  logic [CELL_MAX_W-1:0] cell_a;
  logic [CELL_MAX_W-1:0] cell_b;
  logic [CELL_MAX_W-1:0] cell_r;
  entry_t              lane_rdata [LANES];
  entry_t              sel;

  assign in_smp[0] = item_data.sample_ch0;
  assign in_smp[1] = item_data.sample_ch1;
  assign in_smp[2] = item_data.sample_ch2;
  assign in_smp[3] = item_data.sample_ch3;

  assign pos_ok = item_data.sample_pos < POS_W'(EVENT_SAMPLES);
  assign ch_ok  = {1'b0, item_data.read_channel} < (CH_W + 1)'(LANES);
  assign sum_a  = {1'b0, item_data.offset_pair_a} + {1'b0, item_data.sample_pos};
  assign sum_b  = {1'b0, item_data.offset_pair_b} + {1'b0, item_data.sample_pos};
  assign cell_a = mod_cells(sum_a, CELLS);
  assign cell_b = mod_cells(sum_b, CELLS);
  assign cell_r = mod_cells({1'b0, item_data.read_cell}, CELLS);

  // Latch the decoded item on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_accum <= 1'b0;
      is_read  <= 1'b0;
      rd_clear <= 1'b0;
      rd_zero  <= 1'b0;
    end else if (cmd.load) begin
      is_accum <= (item_data.operation == OP_ACCUM) && pos_ok;
      is_read  <= (item_data.operation == OP_READ) ||
                  (item_data.operation == OP_READ_CLEAR);
      rd_clear <= (item_data.operation == OP_READ_CLEAR) && ch_ok;
      rd_zero  <= !ch_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pair_addr[0] <= cell_a[CELL_W-1:0];
      pair_addr[1] <= cell_b[CELL_W-1:0];
      rd_addr      <= cell_r[CELL_W-1:0];
      rd_lane      <= item_data.read_channel[LANE_W-1:0];
      for (int l = 0; l < LANES; l++) begin
        smp[l] <= in_smp[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    entry_t            mem [CELLS];
    entry_t            rdata;
    entry_t            upd_e;
    entry_t            wd;
    logic [CELL_W-1:0] ra;
    logic [CELL_W-1:0] wa;
    logic              we;
    logic [SUM_W:0]    sum_ext;
    logic              sum_ov;
    logic              cnt_max;

    assign ra = is_accum ? pair_addr[l >> 1] : rd_addr;

    always_comb begin
      sum_ext     = {1'b0, rdata.sum} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, smp[l]};
      sum_ov      = sum_ext[SUM_W];
      cnt_max     = &rdata.count;
      upd_e.sum   = sum_ov ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      upd_e.count = cnt_max ? rdata.count : rdata.count + 1'b1;
      upd_e.sat   = rdata.sat || sum_ov || cnt_max;
    end

    always_comb begin
      we = 1'b0;
      wa = ra;
      wd = '0;
      if (cmd.clr_step) begin
        we = 1'b1;
        wa = clr_addr;
      end else if (cmd.upd && is_accum) begin
        we = 1'b1;
        wd = upd_e;
      end else if (cmd.upd && rd_clear && (rd_lane == LANE_W'(l))) begin
        we = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= wd;
      end
      if (cmd.rd) begin
        rdata <= mem[ra];
      end
    end

    assign lane_rdata[l] = rdata;
  end

  assign sel = lane_rdata[rd_lane];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.upd && is_read) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && is_read) begin
      if (rd_zero) begin
        result_data <= '0;
      end else begin
        result_data.cell_sum   <= sel.sum;
        result_data.cell_count <= sel.count;
        result_data.saturated  <= sel.sat;
      end
    end
  end

  assign status.clr_last = (clr_addr == CELL_W'(CELLS - 1));
  assign status.need_out = is_read;
  assign status.out_free = !result_valid || !result_stall;

endmodule

`default_nettype wire

FILE: hw/rtl/rotated_cell_statistics_accumulator.sv
// Top level of the rotated cell statistics accumulator: controller, datapath and checks.
`default_nettype none

// Per-cell calibration statistics for a four-input circular sampling array.
// An accumulate transaction adds each channel sample into the sum of cell
// (offset + position) mod CELLS of its channel and bumps that cell's hit
// count; channels 0/1 take offset_pair_a, channels 2/3 take offset_pair_b.
// Positions of 1000 and above are dropped, as are inputs for channels at or
// beyond CHANNELS. Sums (40 bits) and counts (24 bits) saturate and set a
// sticky flag. Read and read-and-clear transactions return one cell's sum,
// count and flag; a channel at or beyond CHANNELS reads as all zero. Each
// channel keeps its cells in its own single-port memory, so the datapath
// runs a read-modify-write per transaction: each item passes through accept,
// memory read and write-back, and a read waits in write-back while the
// previous result is still stalled in the output register. The next item is
// accepted as soon as write-back is done, whether or not the result has been
// taken. After reset a clearing pass zeroes all memories, during which
// item_stall stays high.
module rotated_cell_statistics_accumulator
  import rcsa_pkg::*;
#(
  parameter int CELLS    = DEF_CELLS,
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item_data,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result_data
);

  // Only channels that have a sample input get a memory.
  localparam int LANES = (CHANNELS < SAMPLE_INPUTS) ? CHANNELS : SAMPLE_INPUTS;

  dp_cmd_t    cmd;
  dp_status_t status;

  rcsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  rcsa_datapath #(
    .CELLS (CELLS),
    .LANES (LANES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_data    (item_data),
    .result_data  (result_data),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

`ifndef SYNTHESIS
  // One transaction at a time: the cycle after an accept never accepts.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while the previous one is in flight");

  // A fresh result is registered at write-back, after its transaction's memory read.
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall, 3))
    else $error("result not aligned to its transaction");

  // Only read transactions produce results.
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      ($past(item_data.operation, 3) == OP_READ ||
       $past(item_data.operation, 3) == OP_READ_CLEAR))
    else $error("result produced by a non-read transaction");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the rotated cell statistics accumulator: shadow store, driver, monitor.
`default_nettype none

module tb_top;
  import rcsa_pkg::*;

  // Store layout mirrors the block at its default size: one entry per cell and channel.
  localparam int STORE_DEPTH = DEF_CELLS * DEF_CHANNELS;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  // Unused operation code: the block ignores it and returns nothing.
  localparam logic [OP_W-1:0]    OP_NONE   = 2'd3;
  localparam int RANDOM_FRAMES = 1380;
  localparam int TAIL_FRAMES   = 150;
  localparam int SETTLE_CYCLES = 12;

  // One queued stimulus frame; drain_first holds it back until every readout is in.
  typedef struct packed {
    logic     drain_first;
    in_item_t item;
  } frame_t;

  logic      clk;
  logic      rst;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item_data = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result_data;

  rotated_cell_statistics_accumulator dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // Shadow copy of the per-cell statistics, indexed cell * CHANNELS + channel.
  logic [SUM_W-1:0]   shadow_sum   [STORE_DEPTH];
  logic [COUNT_W-1:0] shadow_count [STORE_DEPTH];
  logic               shadow_sat   [STORE_DEPTH];

  frame_t    frame_q[$];         // frames waiting for the driver
  out_item_t cell_readouts_q[$]; // readouts owed by the block, oldest first
  int        mismatches = 0;

  int        gap_left   = 0;
  int        stall_left = 0;
  logic      calm       = 1'b0;  // stretch with no idling on either side
  logic      quiet_tail = 1'b0;  // last part of the run: no idling at all
  frame_t    next_frame;
  logic      has_readout;
  out_item_t readout;

  // Free-running clock, period 10.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (clearing pass plus ~1400 frames with stalls).
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Add one sample into a cell, saturating sum and count and setting the sticky flag.
  task automatic add_cell_sample(input int cell_no, input int ch,
                                 input logic [SAMPLE_W-1:0] value);
    int               idx;
    logic [SUM_W:0]   wide_sum;
    idx = cell_no * DEF_CHANNELS + ch;
    wide_sum = {1'b0, shadow_sum[idx]} + {{(SUM_W+1-SAMPLE_W){1'b0}}, value};
    if (wide_sum[SUM_W]) begin
      shadow_sum[idx] = SUM_MAX;
      shadow_sat[idx] = 1'b1;
    end else begin
      shadow_sum[idx] = wide_sum[SUM_W-1:0];
    end
    if (shadow_count[idx] == COUNT_MAX) begin
      shadow_sat[idx] = 1'b1;
    end else begin
      shadow_count[idx] = shadow_count[idx] + 1'b1;
    end
  endtask

  // Apply one accepted transaction to the shadow store; report the readout it owes, if any.
  task automatic accumulate_cell_stats(input in_item_t it, output logic owes,
                                       output out_item_t res);
    int                  pos;
    int                  cell_no;
    int                  ch;
    int                  idx;
    logic [SAMPLE_W-1:0] samples [SAMPLE_INPUTS];
    owes = 1'b0;
    res  = '0;
    pos  = int'(it.sample_pos);
    samples[0] = it.sample_ch0;
    samples[1] = it.sample_ch1;
    samples[2] = it.sample_ch2;
    samples[3] = it.sample_ch3;
    case (it.operation)
      OP_ACCUM: begin
        // Positions past the recorded event are dropped whole.
        if (pos < EVENT_SAMPLES) begin
          for (ch = 0; ch < SAMPLE_INPUTS && ch < DEF_CHANNELS; ch++) begin
            cell_no = ((ch < 2 ? int'(it.offset_pair_a) : int'(it.offset_pair_b)) + pos)
                      % DEF_CELLS;
            add_cell_sample(cell_no, ch, samples[ch]);
          end
        end
      end
      OP_READ, OP_READ_CLEAR: begin
        owes    = 1'b1;
        cell_no = int'(it.read_cell) % DEF_CELLS;
        ch      = int'(it.read_channel);
        // A channel the block does not have reads as all zero and clears nothing.
        if (ch < DEF_CHANNELS) begin
          idx = cell_no * DEF_CHANNELS + ch;
          res.cell_sum   = shadow_sum[idx];
          res.cell_count = shadow_count[idx];
          res.saturated  = shadow_sat[idx];
          if (it.operation == OP_READ_CLEAR) begin
            shadow_sum[idx]   = '0;
            shadow_count[idx] = '0;
            shadow_sat[idx]   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compare one taken readout with the oldest one owed, field by field.
  task automatic check_readout(input out_item_t got);
    out_item_t want;
    if (cell_readouts_q.size() == 0) begin
      $display("%0t: unexpected readout, expected none, actual sum %0h count %0h sat %0b",
               $time, got.cell_sum, got.cell_count, got.saturated);
      mismatches++;
    end else begin
      want = cell_readouts_q.pop_front();
      if (got.cell_sum !== want.cell_sum) begin
        $display("%0t: cell_sum mismatch, expected %0h, actual %0h",
                 $time, want.cell_sum, got.cell_sum);
        mismatches++;
      end
      if (got.cell_count !== want.cell_count) begin
        $display("%0t: cell_count mismatch, expected %0h, actual %0h",
                 $time, want.cell_count, got.cell_count);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
        mismatches++;
      end
    end
  endtask

  function automatic in_item_t make_frame(
      input logic [OP_W-1:0] op, input int pos,
      input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
      input logic [SAMPLE_W-1:0] s2, input logic [SAMPLE_W-1:0] s3,
      input int offs_a, input int offs_b, input int rd_cell, input int rd_ch);
    in_item_t it;
    it.operation     = op;
    it.sample_pos    = POS_W'(pos);
    it.sample_ch0    = s0;
    it.sample_ch1    = s1;
    it.sample_ch2    = s2;
    it.sample_ch3    = s3;
    it.offset_pair_a = POS_W'(offs_a);
    it.offset_pair_b = POS_W'(offs_b);
    it.read_cell     = POS_W'(rd_cell);
    it.read_channel  = CH_W'(rd_ch);
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    return ($urandom_range(0, 7) == 0) ? {SAMPLE_W{1'b1}} : SAMPLE_W'($urandom);
  endfunction

  // Most frames aim at a small set of hot cells (including the wrap past the last cell) so
  // that reads return real sums; the rest spread over the full field ranges.
  function automatic in_item_t rand_frame();
    in_item_t it;
    int       pick;
    it = make_frame(OP_ACCUM, int'($urandom_range(0, 1023)), rand_sample(), rand_sample(),
                    rand_sample(), rand_sample(), int'($urandom_range(0, 1023)),
                    int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                    int'($urandom_range(0, 3)));
    pick = int'($urandom_range(0, 99));
    if (pick < 5)       it.operation = OP_NONE;
    else if (pick < 55) it.operation = OP_ACCUM;
    else if (pick < 85) it.operation = OP_READ;
    else                it.operation = OP_READ_CLEAR;
    if ($urandom_range(0, 3) != 0) begin
      it.sample_pos    = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(1000, 1023))
                                                     : POS_W'($urandom_range(0, 9));
      it.offset_pair_a = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 5))
                                              : POS_W'($urandom_range(1018, 1023));
      it.offset_pair_b = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 5))
                                              : POS_W'($urandom_range(1018, 1023));
      it.read_cell     = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 14))
                                              : POS_W'($urandom_range(1018, 1023));
    end
    return it;
  endfunction

  task automatic queue_frame(input in_item_t it, input logic drain);
    frame_t f;
    f.drain_first = drain;
    f.item        = it;
    frame_q.push_back(f);
  endtask

  // Toggle calm stretches now and then so both sides see runs with no idling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) begin
      calm <= !calm;
    end
  end

  // Driver: record each accepted transaction in the shadow store, then present the next
  // frame, hold a stalled one, or idle for a gap burst or a drain pause.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        accumulate_cell_stats(item_data, has_readout, readout);
        if (has_readout) begin
          cell_readouts_q.push_back(readout);
        end
      end
      if (item_valid && item_stall) begin
        // hold the stalled transaction unchanged
      end else if (gap_left > 0) begin
        item_valid <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (frame_q.size() == 0 ||
                   (frame_q[0].drain_first && cell_readouts_q.size() != 0)) begin
        item_valid <= 1'b0;
      end else begin
        next_frame = frame_q.pop_front();
        item_valid <= 1'b1;
        item_data  <= next_frame.item;
        if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
          gap_left <= int'($urandom_range(1, 5));
        end
        quiet_tail <= (frame_q.size() < TAIL_FRAMES);
      end
    end
  end

  // Monitor: check each taken readout, then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        check_readout(result_data);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        stall_left   <= int'($urandom_range(0, 4));
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    in_item_t it;
    int       counted;
    logic     first;

    for (int i = 0; i < STORE_DEPTH; i++) begin
      shadow_sum[i]   = '0;
      shadow_count[i] = '0;
      shadow_sat[i]   = 1'b0;
    end

    // Directed part: a read of untouched state, full-scale samples twice into cell 0, the
    // last in-event position with maximum offsets (wraps), positions past the event,
    // split offsets that wrap differently per pair, then reads, a clear, and the idle op.
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_frame(make_frame(OP_ACCUM, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           0, 0, 0, 0), 1'b0);
    queue_frame(make_frame(OP_ACCUM, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           0, 0, 1023, 3), 1'b0);
    queue_frame(make_frame(OP_ACCUM, 999, 1, 2, 3, 4, 1023, 1023, 0, 0), 1'b0);
    queue_frame(make_frame(OP_ACCUM, 1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           0, 0, 0, 0), 1'b0);
    queue_frame(make_frame(OP_ACCUM, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           1023, 1023, 0, 0), 1'b0);
    queue_frame(make_frame(OP_ACCUM, 5, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555,
                           1023, 1020, 0, 0), 1'b0);
    for (int ch = 0; ch < 4; ch++) begin
      queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, ch), 1'b0);
    end
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 998, 0), 1'b0);
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 998, 3), 1'b0);
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1000, 0), 1'b0);
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 4, 1), 1'b0);
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 2), 1'b0);
    queue_frame(make_frame(OP_READ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_frame(make_frame(OP_NONE, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           1023, 1023, 1023, 3), 1'b0);
    queue_frame(make_frame(OP_READ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1023, 3), 1'b0);
    queue_frame(make_frame(OP_READ_CLEAR, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           1023, 1023, 998, 3), 1'b0);
    queue_frame(make_frame(OP_READ, 0, 0, 0, 0, 0, 0, 0, 998, 3), 1'b0);

    // Random part; the first frame waits for the directed readouts to drain, later
    // ones do so now and then.
    counted = 0;
    first   = 1'b1;
    while (counted < RANDOM_FRAMES) begin
      it = rand_frame();
      queue_frame(it, first || ($urandom_range(0, 199) == 0));
      first = 1'b0;
      counted++;
    end

    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last transaction to go in, then for every owed readout, then settle.
    while (frame_q.size() != 0 || item_valid) @(posedge clk);
    while (cell_readouts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/rcsa_pkg.sv
hw/rtl/rcsa_ctrl.sv
hw/rtl/rcsa_datapath.sv
hw/rtl/rotated_cell_statistics_accumulator.sv
tb/tb_top.sv
